[hdl/pfa_pkg.sv]
// pfa_pkg: shared types and codes for the partition fit allocator
// holds the command and result word types, the state type, policy and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

	localparam int AMOUNT_BITS = 16;
	localparam int LOAD_IDX_BITS = 4;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_ALLOC = 1'b1
	} cmd_t;

	localparam logic [1:0] POLICY_FIRST = 2'd0;
	localparam logic [1:0] POLICY_BEST  = 2'd1;
	localparam logic [1:0] POLICY_WORST = 2'd2;

	localparam logic REG_FIT_POLICY    = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	typedef struct packed {
		cmd_t                     cmd;
		logic [LOAD_IDX_BITS-1:0] load_index;
		logic [AMOUNT_BITS-1:0]   amount;
	} item_word_t;

	typedef struct packed {
		logic                     granted;
		logic [LOAD_IDX_BITS-1:0] chosen_block;
		logic [AMOUNT_BITS-1:0]   space_left;
	} result_word_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

`default_nettype wire

[hdl/partition_fit_allocator.sv]
// partition_fit_allocator: first / best / worst fit block allocator
// free size table in an on-chip memory, scanned by one shared compare unit
// depends on pfa_pkg
//
// usage:
//   a command word is taken at a rising edge with start high and busy low.
//   a load word writes one block's free size in that edge and leaves busy low,
//   so loads can follow each other every cycle; it gives no result.
//   an allocate word raises busy and scans blocks 0 .. blocks_in_use-1 (at
//   most NUM_BLOCKS-1), one table read and one compare per cycle, bounded by
//   the single table read port; a block is compared in the cycle after its
//   read. the chosen block is written back in the last scan cycle.
//   the result word is shown for exactly one cycle with done high, in the
//   first cycle with busy low again; a new word may be started in that same cycle.
//   the receiver cannot stall: it must take the result when done is high.
//   configuration sits on an apb port: fit_policy at 0x0, blocks_in_use at
//   0x4; the user writes them only while busy is low; it is not enforced.
//   reset clears the configuration registers and the sequencer; the table
//   holds nothing defined until a load word writes it.
`timescale 1ns / 1ps
`default_nettype none

module partition_fit_allocator #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  pfa_pkg::item_word_t   item,
	output logic                  busy,
	output logic                  done,
	output pfa_pkg::result_word_t result,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [2:0]            paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int AMT_W = pfa_pkg::AMOUNT_BITS;
	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];

	logic [1:0]           policy_q;
	logic [4:0]           blocks_q;
	pfa_pkg::state_t      state_q;
	logic [CNT_W-1:0]     rd_q;
	logic [CNT_W-1:0]     limit_q;
	logic [AMT_W-1:0]     amount_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [SIZE_BITS-1:0] rdata_s1;

	logic                 cfg_we;
	logic                 take;
	logic                 load_we;
	logic                 issue;
	logic                 scan_end;
	logic                 fits;
	logic                 better;
	logic [CNT_W-1:0]     limit_d;
	logic [SIZE_BITS-1:0] new_size;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [SIZE_BITS-1:0] mem_wdata;

	// apb side
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_comb begin
		if (paddr[2] == pfa_pkg::REG_BLOCKS_IN_USE) begin
			prdata = {27'd0, blocks_q};
		end else begin
			prdata = {30'd0, policy_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfa_pkg::POLICY_FIRST;
			blocks_q <= 5'd0;
		end else if (cfg_we) begin
			if (paddr[2] == pfa_pkg::REG_BLOCKS_IN_USE) begin
				blocks_q <= pwdata[4:0];
			end else begin
				policy_q <= pwdata[1:0];
			end
		end
	end

	// command side
	assign busy    = (state_q != pfa_pkg::ST_IDLE);
	assign take    = start & ~busy;
	assign load_we = take & (item.cmd == pfa_pkg::CMD_LOAD)
		& (32'(item.load_index) < NUM_BLOCKS);

	always_comb begin
		if (32'(blocks_q) > NUM_BLOCKS) begin
			limit_d = CNT_W'(NUM_BLOCKS);
		end else begin
			limit_d = CNT_W'(blocks_q);
		end
	end

	assign issue    = (state_q == pfa_pkg::ST_SCAN) && (rd_q != limit_q);
	assign scan_end = (state_q == pfa_pkg::ST_SCAN) && (rd_q == limit_q) && !vld_s1;

	// shared compare unit: fit test and policy compare against the current pick
	assign fits = CMP_W'(amount_q) <= CMP_W'(rdata_s1);
	always_comb begin
		case (policy_q)
			pfa_pkg::POLICY_BEST:  better = rdata_s1 < best_q;
			pfa_pkg::POLICY_WORST: better = rdata_s1 > best_q;
			default:               better = 1'b0;
		endcase
	end

	// request is known to fit, so this cannot go negative
	assign new_size = SIZE_BITS'(CMP_W'(best_q) - CMP_W'(amount_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfa_pkg::ST_IDLE;
			rd_q    <= '0;
			limit_q <= '0;
			found_q <= 1'b0;
			vld_s1  <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				pfa_pkg::ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (take && item.cmd == pfa_pkg::CMD_ALLOC) begin
						rd_q    <= '0;
						limit_q <= limit_d;
						found_q <= 1'b0;
						state_q <= pfa_pkg::ST_SCAN;
					end
				end
				pfa_pkg::ST_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (vld_s1 && fits) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						done    <= 1'b1;
						state_q <= pfa_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pfa_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			amount_q <= item.amount;
		end
		idx_s1 <= rd_q[IDX_W-1:0];
		if (vld_s1 && fits && (!found_q || better)) begin
			pick_q <= idx_s1;
			best_q <= rdata_s1;
		end
		if (scan_end) begin
			if (found_q) begin
				result.granted      <= 1'b1;
				result.chosen_block <= pfa_pkg::LOAD_IDX_BITS'(pick_q);
				result.space_left   <= AMT_W'(new_size);
			end else begin
				result.granted      <= 1'b0;
				result.chosen_block <= '0;
				result.space_left   <= '0;
			end
		end
	end

	// free size table, one write and one registered read port
	always_comb begin
		if (scan_end) begin
			mem_we    = found_q;
			mem_waddr = pick_q;
			mem_wdata = new_size;
		end else begin
			mem_we    = load_we;
			mem_waddr = IDX_W'(item.load_index);
			mem_wdata = SIZE_BITS'(item.amount);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[rd_q[IDX_W-1:0]];
	end

endmodule

`default_nettype wire
